// ===== src/clt_pkg.sv =====
`default_nettype none
package clt_pkg;

   localparam int MAX_NESTING = 255;
   localparam int MAX_TOKENS  = 255;

   localparam logic [7:0] DEPTH_CAP = (MAX_NESTING > 255) ? 8'd255 : 8'(MAX_NESTING);
   localparam logic [7:0] INDEX_CAP = (MAX_TOKENS - 1 > 255) ? 8'd255 : 8'(MAX_TOKENS - 1);

   localparam logic [7:0] COMMENT_RESET = 8'd35;

   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'd39;
   localparam logic [7:0] CH_OPEN   = 8'd40;
   localparam logic [7:0] CH_CLOSE  = 8'd41;
   localparam logic [7:0] CH_BSLASH = 8'd92;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_BOUND = 2'd1,
      KIND_LINE  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_BRACKET = 2'd2,
      ST_QUOTE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CLS_EOL,
      CLS_COMMENT,
      CLS_QUOTE,
      CLS_BSLASH,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_SPACE,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic       lit;   // raw byte is quote or backslash (escapable)
      logic [7:0] data;
   } entry_type;

endpackage
`default_nettype wire

// ===== src/clt_req_if.sv =====
`default_nettype none
interface clt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink (input valid, input line_byte, output ready);
endinterface
`default_nettype wire

// ===== src/clt_rsp_if.sv =====
`default_nettype none
interface clt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] token_char;
   logic [7:0] token_index;
   logic [1:0] line_status;

   modport source (output valid, output kind, output token_char, output token_index,
                   output line_status, input ready);
   modport sink (input valid, input kind, input token_char, input token_index,
                 input line_status, output ready);
endinterface
`default_nettype wire

// ===== src/clt_csr_if.sv =====
`default_nettype none
interface clt_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] comment_char;

   modport source (output valid, output comment_char, input ready);
   modport sink (input valid, input comment_char, output ready);
endinterface
`default_nettype wire

// ===== src/command_line_tokenizer.sv =====
// Path: an accepted byte is written into the queue, then the back end pops it and updates
// the output register, from which any result for that byte is shown.
// Throughput: one byte per clock while out_ready holds; the two-entry queue and the output
// register let either side stall alone. The back-end state update per byte sets the rate.
// Reset: synchronous, active high; clears line state, queue and comment byte (to '#').
`default_nettype none
module command_line_tokenizer (
   input  wire logic  clock,
   input  wire logic  reset,
   clt_req_if.sink    req_bus,
   clt_rsp_if.source  rsp_bus,
   clt_csr_if.sink    csr_bus
);
   import clt_pkg::*;

   logic               push;
   logic               q_full;
   entry_type          push_entry;
   logic               pop;
   logic               q_valid;
   entry_type          head;
   logic [QCNT_W-1:0]  q_count;

   clt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_byte    (req_bus.line_byte),
      .cfg_valid  (csr_bus.valid),
      .cfg_ready  (csr_bus.ready),
      .cfg_data   (csr_bus.comment_char),
      .push       (push),
      .q_full     (q_full),
      .push_entry (push_entry)
   );

   clt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .head       (head),
      .count      (q_count)
   );

   clt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_kind   (rsp_bus.kind),
      .out_char   (rsp_bus.token_char),
      .out_index  (rsp_bus.token_index),
      .out_status (rsp_bus.line_status)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count past depth");

   a_status_only_at_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != KIND_LINE |-> rsp_bus.line_status == ST_OK)
      else $error("line status on non-line beat");

   a_char_only_on_char: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != KIND_CHAR |-> rsp_bus.token_char == 8'd0)
      else $error("token char on non-char beat");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid && (q_count != '0))
      else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== src/clt_front.sv =====
`default_nettype none
module clt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              cfg_valid,
   output logic                   cfg_ready,
   input  wire logic [7:0]        cfg_data,
   output logic                   push,
   input  wire logic              q_full,
   output clt_pkg::entry_type     push_entry
);
   import clt_pkg::*;

   logic [7:0] comment_ff;
   logic [7:0] comment_in;

   assign cfg_ready  = 1'b1;
   assign comment_in = (cfg_valid) ? cfg_data : comment_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= COMMENT_RESET;
      end else begin
         comment_ff <= comment_in;
      end
   end

   assign in_ready = !q_full;
   assign push     = in_valid && !q_full;

   // comment byte outranks every class but end of line
   always_comb begin
      push_entry.data = in_byte;
      push_entry.lit  = (in_byte == CH_QUOTE) || (in_byte == CH_BSLASH);
      priority if (in_byte == CH_NL || in_byte == CH_NUL) begin
         push_entry.cls = CLS_EOL;
      end else if (in_byte == comment_ff) begin
         push_entry.cls = CLS_COMMENT;
      end else if (in_byte == CH_QUOTE) begin
         push_entry.cls = CLS_QUOTE;
      end else if (in_byte == CH_BSLASH) begin
         push_entry.cls = CLS_BSLASH;
      end else if (in_byte == CH_OPEN) begin
         push_entry.cls = CLS_OPEN;
      end else if (in_byte == CH_CLOSE) begin
         push_entry.cls = CLS_CLOSE;
      end else if (in_byte == CH_SPACE) begin
         push_entry.cls = CLS_SPACE;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end
endmodule
`default_nettype wire

// ===== src/clt_queue.sv =====
`default_nettype none
module clt_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire clt_pkg::entry_type      push_entry,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         q_valid,
   output clt_pkg::entry_type           head,
   output logic [clt_pkg::QCNT_W-1:0]   count
);
   import clt_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign head    = mem_ff[rd_ff];
   assign count   = cnt_ff;

   always_comb begin
      wr_in  = push ? ptr_next(wr_ff) : wr_ff;
      rd_in  = pop ? ptr_next(rd_ff) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

// ===== src/clt_back.sv =====
`default_nettype none
module clt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire clt_pkg::entry_type  head,
   output logic                     pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [1:0]               out_kind,
   output logic [7:0]               out_char,
   output logic [7:0]               out_index,
   output logic [1:0]               out_status
);
   import clt_pkg::*;

   logic       quote_ff, quote_in;
   logic       esc_ff, esc_in;
   logic [7:0] depth_ff, depth_in;
   logic [7:0] tcount_ff, tcount_in;
   logic       nonempty_ff, nonempty_in;
   logic       skip_ff, skip_in;
   logic       ovalid_ff, ovalid_in;

   kind_type   okind_ff, okind_in;
   logic [7:0] ochar_ff, ochar_in;
   logic [7:0] oidx_ff, oidx_in;
   status_type ostat_ff, ostat_in;

   logic       do_emit, do_bound, do_finish;
   status_type fin_status, cur_status;

   assign pop = q_valid && (!ovalid_ff || out_ready);

   always_comb begin
      if (depth_ff != '0) begin
         cur_status = ST_BRACKET;
      end else if (quote_ff) begin
         cur_status = ST_QUOTE;
      end else if (tcount_ff == '0 && !nonempty_ff) begin
         cur_status = ST_EMPTY;
      end else begin
         cur_status = ST_OK;
      end
   end

   always_comb begin
      quote_in    = quote_ff;
      esc_in      = esc_ff;
      depth_in    = depth_ff;
      tcount_in   = tcount_ff;
      nonempty_in = nonempty_ff;
      skip_in     = skip_ff;
      do_emit     = 1'b0;
      do_bound    = 1'b0;
      do_finish   = 1'b0;
      fin_status  = cur_status;

      if (pop) begin
         if (skip_ff) begin
            if (head.cls == CLS_EOL) begin
               skip_in = 1'b0;
            end
         end else begin
            esc_in = 1'b0;
            if (esc_ff && head.lit) begin
               do_emit = 1'b1;
            end else begin
               unique case (head.cls)
                  CLS_EOL: begin
                     do_finish = 1'b1;
                  end
                  CLS_COMMENT: begin
                     do_finish = 1'b1;
                     skip_in   = 1'b1;
                  end
                  CLS_QUOTE: begin
                     quote_in = !quote_ff;
                  end
                  CLS_BSLASH: begin
                     esc_in = 1'b1;
                  end
                  CLS_OPEN: begin
                     if (!quote_ff && depth_ff < DEPTH_CAP) begin
                        depth_in = depth_ff + 8'd1;
                     end
                     do_emit = 1'b1;
                  end
                  CLS_CLOSE: begin
                     if (!quote_ff && depth_ff == '0) begin
                        // underflow ends the line and skips the rest
                        do_finish  = 1'b1;
                        fin_status = ST_BRACKET;
                        skip_in    = 1'b1;
                     end else begin
                        if (!quote_ff) begin
                           depth_in = depth_ff - 8'd1;
                        end
                        do_emit = 1'b1;
                     end
                  end
                  CLS_SPACE: begin
                     if (!quote_ff && depth_ff == '0) begin
                        do_bound = 1'b1;
                     end else begin
                        do_emit = 1'b1;
                     end
                  end
                  default: begin
                     do_emit = 1'b1;
                  end
               endcase
            end
         end
      end

      if (do_emit) begin
         nonempty_in = 1'b1;
      end
      if (do_bound) begin
         nonempty_in = 1'b0;
         if (tcount_ff < INDEX_CAP) begin
            tcount_in = tcount_ff + 8'd1;
         end
      end
      if (do_finish) begin
         quote_in    = 1'b0;
         esc_in      = 1'b0;
         depth_in    = '0;
         tcount_in   = '0;
         nonempty_in = 1'b0;
      end
   end

   always_comb begin
      okind_in  = okind_ff;
      ochar_in  = ochar_ff;
      oidx_in   = oidx_ff;
      ostat_in  = ostat_ff;
      ovalid_in = ovalid_ff && !out_ready;
      if (pop) begin
         ovalid_in = do_emit || do_bound || do_finish;
         oidx_in   = tcount_ff;
         ochar_in  = do_emit ? head.data : 8'd0;
         ostat_in  = do_finish ? fin_status : ST_OK;
         if (do_finish) begin
            okind_in = KIND_LINE;
         end else if (do_bound) begin
            okind_in = KIND_BOUND;
         end else begin
            okind_in = KIND_CHAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff    <= 1'b0;
         esc_ff      <= 1'b0;
         depth_ff    <= '0;
         tcount_ff   <= '0;
         nonempty_ff <= 1'b0;
         skip_ff     <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         quote_ff    <= quote_in;
         esc_ff      <= esc_in;
         depth_ff    <= depth_in;
         tcount_ff   <= tcount_in;
         nonempty_ff <= nonempty_in;
         skip_ff     <= skip_in;
         ovalid_ff   <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      okind_ff <= okind_in;
      ochar_ff <= ochar_in;
      oidx_ff  <= oidx_in;
      ostat_ff <= ostat_in;
   end

   assign out_valid  = ovalid_ff;
   assign out_kind   = okind_ff;
   assign out_char   = ochar_ff;
   assign out_index  = oidx_ff;
   assign out_status = ostat_ff;
endmodule
`default_nettype wire
